// ===== rtl/ryuv_pkg.sv =====
// Shared types, constants and helpers for the RGB to YCbCr 4:2:0 converter.
package ryuv_pkg;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int CFG_DATA_W     = 16;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  // Luma coefficients
  localparam logic [15:0] Y_R   = 16'd66;
  localparam logic [15:0] Y_G   = 16'd129;
  localparam logic [15:0] Y_B   = 16'd25;
  localparam logic [15:0] Y_RND = 16'd128;
  localparam logic [7:0]  Y_OFS = 8'd16;

  // Chroma coefficients, signed 18-bit working width
  localparam logic signed [17:0] CB_R  = -18'sd38;
  localparam logic signed [17:0] CB_G  = -18'sd74;
  localparam logic signed [17:0] CB_B  = 18'sd112;
  localparam logic signed [17:0] CR_R  = 18'sd112;
  localparam logic signed [17:0] CR_G  = -18'sd94;
  localparam logic signed [17:0] CR_B  = -18'sd18;
  localparam logic signed [17:0] C_RND = 18'sd128;
  localparam logic signed [17:0] C_OFS = 18'sd128;
  localparam logic signed [17:0] C_MAX = 18'sd255;

  // Three 9-bit horizontal pair sums: red, green, blue
  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

  // Arithmetic shift by 8, offset and clamp to a byte
  function automatic logic [7:0] chroma_clamp(input logic signed [17:0] v);
    logic signed [17:0] t;
    t = (v >>> 8) + C_OFS;
    if (t < 18'sd0) begin
      return 8'd0;
    end else if (t > C_MAX) begin
      return 8'd255;
    end else begin
      return t[7:0];
    end
  endfunction

endpackage

// ===== rtl/rgb_to_yuv420_converter_core.sv =====
// RGB24 to BT.601 YCbCr 4:2:0 converter, top level.
//
//  port group     | dir | handshake                 | words
//  pixel          | in  | pixel_valid / pixel_stall | red, green, blue
//  result         | out | result_valid/result_stall | luma, chroma_valid, chroma_blue,
//                 |     |                           | chroma_red, frame_end
//  cfg            | in  | cfg_write                 | cfg_index, cfg_data
//
// One pixel per clock unless result_stall fills the pipeline; the output is registered.
// The line buffer sees at most one access per pixel (write on even rows, read on odd).
// Each pipeline stage holds when the one after it is full and stalled, so bubbles
// are squeezed out and a pixel is still taken while a result waits at the output.
// Synchronous reset clears counters and valid bits; the line buffer is not cleared.
module rgb_to_yuv420_converter_core
  import ryuv_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic [7:0]                red,
  input  logic [7:0]                green,
  input  logic [7:0]                blue,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [7:0]                luma,
  output logic                      chroma_valid,
  output logic [7:0]                chroma_blue,
  output logic [7:0]                chroma_red,
  output logic                      frame_end
);

  localparam int LineDepth = MAX_LINE_WIDTH / 2;
  localparam int AW        = $clog2(LineDepth);
  localparam int CW        = $clog2(MAX_LINE_WIDTH);
  localparam int EWRaw     = $clog2(MAX_LINE_WIDTH + 1);
  localparam int EW        = (EWRaw > FRAME_WIDTH_W) ? EWRaw : FRAME_WIDTH_W;
  localparam int MaxEven   = MAX_LINE_WIDTH - (MAX_LINE_WIDTH % 2);

  // configuration
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0]             eff_w, w_even;
  logic [FRAME_HEIGHT_W-1:0] eff_h, h_even;

  always_comb begin
    w_even = EW'({frame_width[FRAME_WIDTH_W-1:1], 1'b0});
    if (w_even < EW'(2)) begin
      eff_w = EW'(2);
    end else if (w_even > EW'(MaxEven)) begin
      eff_w = EW'(MaxEven);
    end else begin
      eff_w = w_even;
    end
    h_even = {frame_height[FRAME_HEIGHT_W-1:1], 1'b0};
    eff_h  = (h_even == '0) ? FRAME_HEIGHT_W'(2) : h_even;
  end

  // stage handshake
  logic s1_valid, s2_valid;
  logic en1, en2, en3, accept;

  assign en3         = !result_valid || !result_stall;
  assign en2         = !s2_valid || en3;
  assign en1         = !s1_valid || en2;
  assign pixel_stall = !en1;
  assign accept      = pixel_valid && en1;

  // position counters
  logic [CW-1:0]             column_count, column_next;
  logic [FRAME_HEIGHT_W-1:0] row_count, row_next;
  logic [EW-1:0]             col_inc;
  logic [FRAME_HEIGHT_W:0]   row_inc;
  logic                      col_wrap, row_wrap;
  logic [23:0]               held_left_pixel;

  always_comb begin
    col_inc  = EW'(column_count) + EW'(1);
    row_inc  = {1'b0, row_count} + (FRAME_HEIGHT_W + 1)'(1);
    col_wrap = col_inc >= eff_w;
    row_wrap = col_wrap && (row_inc >= {1'b0, eff_h});
    column_next = col_wrap ? '0 : col_inc[CW-1:0];
    if (row_wrap) begin
      row_next = '0;
    end else if (col_wrap) begin
      row_next = row_inc[FRAME_HEIGHT_W-1:0];
    end else begin
      row_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      held_left_pixel <= '0;
    end else if (accept) begin
      column_count <= column_next;
      row_count    <= row_next;
      if (!column_count[0]) begin
        held_left_pixel <= {red, green, blue};
      end
    end
  end

  // pair sums and line buffer
  pair_sum_t       pair_sum, rd_data;
  logic [AW-1:0]   slot;
  logic            mem_we, mem_re;
  pair_sum_t       line_mem [LineDepth];

  assign pair_sum.red   = {1'b0, red}   + {1'b0, held_left_pixel[23:16]};
  assign pair_sum.green = {1'b0, green} + {1'b0, held_left_pixel[15:8]};
  assign pair_sum.blue  = {1'b0, blue}  + {1'b0, held_left_pixel[7:0]};
  assign slot   = column_count[AW:1];
  assign mem_we = accept && column_count[0] && !row_count[0];
  assign mem_re = accept && column_count[0] && row_count[0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[slot] <= pair_sum;
    end
    if (mem_re) begin
      rd_data <= line_mem[slot];
    end
  end

  // stage 1: pixel and current pair sum
  logic [7:0] s1_red, s1_green, s1_blue;
  pair_sum_t  s1_sum;
  logic       s1_chroma, s1_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red    <= red;
      s1_green  <= green;
      s1_blue   <= blue;
      s1_sum    <= pair_sum;
      s1_chroma <= mem_re;
      s1_fend   <= row_wrap;
    end
  end

  // stage 2: luma and block averages
  logic [15:0] y_sum;
  logic [9:0]  quad_r, quad_g, quad_b;
  logic [7:0]  s2_luma, s2_ra, s2_ga, s2_ba;
  logic        s2_chroma, s2_fend;

  assign y_sum  = Y_R * {8'd0, s1_red} + Y_G * {8'd0, s1_green}
                + Y_B * {8'd0, s1_blue} + Y_RND;
  assign quad_r = {1'b0, s1_sum.red}   + {1'b0, rd_data.red};
  assign quad_g = {1'b0, s1_sum.green} + {1'b0, rd_data.green};
  assign quad_b = {1'b0, s1_sum.blue}  + {1'b0, rd_data.blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2_luma   <= y_sum[15:8] + Y_OFS;
      s2_ra     <= quad_r[9:2];
      s2_ga     <= quad_g[9:2];
      s2_ba     <= quad_b[9:2];
      s2_chroma <= s1_chroma;
      s2_fend   <= s1_fend;
    end
  end

  // stage 3: chroma, output register
  logic signed [17:0] ra_s, ga_s, ba_s, cb_sum, cr_sum;

  assign ra_s   = 18'(s2_ra);
  assign ga_s   = 18'(s2_ga);
  assign ba_s   = 18'(s2_ba);
  assign cb_sum = CB_R * ra_s + CB_G * ga_s + CB_B * ba_s + C_RND;
  assign cr_sum = CR_R * ra_s + CR_G * ga_s + CR_B * ba_s + C_RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en3) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && s2_valid) begin
      luma         <= s2_luma;
      chroma_valid <= s2_chroma;
      chroma_blue  <= s2_chroma ? chroma_clamp(cb_sum) : 8'd0;
      chroma_red   <= s2_chroma ? chroma_clamp(cr_sum) : 8'd0;
      frame_end    <= s2_fend;
    end
  end

  // checks
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (s1_valid && s2_valid && result_valid && result_stall))
    else $error("input stalled with room in the pipeline");

  a_mem_one_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("line buffer read and write in one cycle");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && row_wrap) |=> (column_count == '0 && row_count == '0))
    else $error("counters not cleared after last pixel of frame");

  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !chroma_valid) |-> (chroma_blue == 8'd0 && chroma_red == 8'd0))
    else $error("chroma word nonzero without chroma_valid");

endmodule
